FILE: sv/assert_macros.svh
// Assertion macros shared by the homing sequencer RTL.
// Depends on a clock named clk and a synchronous reset named rst in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define HSU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define HSU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/hsu_pkg.sv
// Shared types, codes and helpers for the two-axis homing sequencer.
// No dependencies; used by hsu_rule, hsu_step_chain and the top level.
package hsu_pkg;

  // Field widths
  localparam int SWITCH_BITS    = 4;
  localparam int SWITCH_COUNT   = 4;
  localparam int PHASE_BITS     = 4;
  localparam int MARGIN_BITS    = 16;
  localparam int LEN_BITS       = 24;
  localparam int SW_IDX_BITS    = 2;
  localparam int IN_TDATA_BITS  = 8;
  localparam int OUT_TDATA_BITS = 72;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;

  // Number of phase-rule evaluations chained within one tick
  localparam int RULE_PASSES = 4;

  localparam logic [SWITCH_BITS-1:0] SWITCH_MASK =
    (SWITCH_COUNT >= SWITCH_BITS) ? {SWITCH_BITS{1'b1}}
                                  : SWITCH_BITS'((1 << SWITCH_COUNT) - 1);

  // Sequencer phase codes
  localparam logic [PHASE_BITS-1:0] PH_IDLE    = 4'd0;
  localparam logic [PHASE_BITS-1:0] PH_WAIT    = 4'd1;
  localparam logic [PHASE_BITS-1:0] PH_X_FIRST = 4'd2;
  localparam logic [PHASE_BITS-1:0] PH_Y_FIRST = 4'd8;
  localparam logic [PHASE_BITS-1:0] PH_UNUSED  = 4'd14;
  localparam logic [PHASE_BITS-1:0] PH_DONE    = 4'd15;

  // Step within one axis
  localparam logic [2:0] SUB_SEEK_POS   = 3'd0;
  localparam logic [2:0] SUB_AWAY_POS   = 3'd1;
  localparam logic [2:0] SUB_MARGIN_POS = 3'd2;
  localparam logic [2:0] SUB_SEEK_NEG   = 3'd3;
  localparam logic [2:0] SUB_AWAY_NEG   = 3'd4;
  localparam logic [2:0] SUB_MARGIN_NEG = 3'd5;

  // Configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_X_DIR  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_Y_DIR  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MARGIN = 2'd2;

  typedef struct packed {
    logic                   x_dir;
    logic                   y_dir;
    logic [MARGIN_BITS-1:0] margin_steps;
  } hsu_cfg_t;

  // Everything one rule evaluation reads and writes, except the travel count
  typedef struct packed {
    logic                                   busy;
    logic                                   start;
    logic [PHASE_BITS-1:0]                  phase;
    logic [MARGIN_BITS-1:0]                 margin_left;
    logic [3:0][SW_IDX_BITS-1:0]            found;
    logic [1:0][LEN_BITS-1:0]               lengths;
    logic                                   step_x;
    logic                                   dir_x;
    logic                                   step_y;
    logic                                   dir_y;
  } hsu_ctx_t;

  // Index of the lowest closed switch, zero when none is closed
  function automatic logic [SW_IDX_BITS-1:0] lowest_closed(logic [SWITCH_BITS-1:0] closed);
    logic [SW_IDX_BITS-1:0] idx;
    idx = '0;
    for (int i = SWITCH_BITS - 1; i >= 0; i--) begin
      if (closed[i]) begin
        idx = SW_IDX_BITS'(i);
      end
    end
    return idx;
  endfunction

endpackage

FILE: sv/hsu_rule.sv
// One evaluation of the homing phase rule: combinational, passes through when not busy.
// Depends on hsu_pkg.
module hsu_rule #(
  parameter int COUNT_BITS = 24
) (
  input  hsu_pkg::hsu_cfg_t                 cfg,
  input  logic [hsu_pkg::SWITCH_BITS-1:0]   closed,
  input  hsu_pkg::hsu_ctx_t                 ctx_in,
  input  logic [COUNT_BITS-1:0]             travel_in,
  output hsu_pkg::hsu_ctx_t                 ctx_out,
  output logic [COUNT_BITS-1:0]             travel_out
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
  localparam logic [COUNT_BITS-1:0] CNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};

  logic                                axis;
  logic [hsu_pkg::PHASE_BITS-1:0]      rel;
  logic [2:0]                          sub;
  logic                                pos_dir;
  logic                                any_closed;
  logic [hsu_pkg::SW_IDX_BITS-1:0]     low_idx;
  logic [COUNT_BITS-1:0]               count_up;
  logic [COUNT_BITS-1:0]               count_down;
  logic                                do_step;
  logic                                step_level;

  // Decode axis and step within the axis
  assign axis       = (ctx_in.phase >= hsu_pkg::PH_Y_FIRST);
  assign rel        = ctx_in.phase - (axis ? hsu_pkg::PH_Y_FIRST : hsu_pkg::PH_X_FIRST);
  assign sub        = rel[2:0];
  assign pos_dir    = axis ? cfg.y_dir : cfg.x_dir;
  assign any_closed = |closed;
  assign low_idx    = hsu_pkg::lowest_closed(closed);

  // Saturating travel count
  assign count_up   = (travel_in == CNT_MAX) ? travel_in : travel_in + COUNT_BITS'(1);
  assign count_down = (travel_in == CNT_MIN) ? travel_in : travel_in - COUNT_BITS'(1);

  // Apply the rule of the current phase
  always_comb begin
    ctx_out    = ctx_in;
    travel_out = travel_in;
    do_step    = 1'b0;
    step_level = 1'b0;
    if (ctx_in.busy) begin
      if (ctx_in.phase == hsu_pkg::PH_IDLE || ctx_in.phase == hsu_pkg::PH_UNUSED ||
          ctx_in.phase == hsu_pkg::PH_DONE) begin
        if (ctx_in.start) begin
          ctx_out.phase = hsu_pkg::PH_WAIT;
          ctx_out.start = 1'b0;
          travel_out    = '0;
        end else begin
          ctx_out.busy = 1'b0;
        end
      end else if (ctx_in.phase == hsu_pkg::PH_WAIT) begin
        if (any_closed) begin
          ctx_out.busy = 1'b0;
        end else begin
          ctx_out.phase = hsu_pkg::PH_X_FIRST;
        end
      end else begin
        case (sub)
          hsu_pkg::SUB_SEEK_POS: begin
            if (!any_closed) begin
              do_step    = 1'b1;
              step_level = pos_dir;
            end else begin
              ctx_out.found[{axis, 1'b0}] = low_idx;
              ctx_out.phase = ctx_in.phase + 4'd1;
            end
          end
          hsu_pkg::SUB_AWAY_POS: begin
            if (any_closed) begin
              do_step    = 1'b1;
              step_level = ~pos_dir;
            end else begin
              ctx_out.margin_left = cfg.margin_steps;
              ctx_out.phase       = ctx_in.phase + 4'd1;
            end
          end
          hsu_pkg::SUB_MARGIN_POS: begin
            if (ctx_in.margin_left != '0) begin
              ctx_out.margin_left = ctx_in.margin_left - 16'd1;
              do_step    = 1'b1;
              step_level = ~pos_dir;
            end else begin
              travel_out    = '0;
              ctx_out.phase = ctx_in.phase + 4'd1;
            end
          end
          hsu_pkg::SUB_SEEK_NEG: begin
            if (!any_closed) begin
              do_step    = 1'b1;
              step_level = ~pos_dir;
              travel_out = count_up;
            end else begin
              ctx_out.found[{axis, 1'b1}] = low_idx;
              ctx_out.phase = ctx_in.phase + 4'd1;
            end
          end
          hsu_pkg::SUB_AWAY_NEG: begin
            if (any_closed) begin
              do_step    = 1'b1;
              step_level = pos_dir;
              travel_out = count_down;
            end else begin
              ctx_out.margin_left = cfg.margin_steps;
              ctx_out.phase       = ctx_in.phase + 4'd1;
            end
          end
          hsu_pkg::SUB_MARGIN_NEG: begin
            if (ctx_in.margin_left != '0) begin
              ctx_out.margin_left = ctx_in.margin_left - 16'd1;
              do_step    = 1'b1;
              step_level = pos_dir;
              travel_out = count_down;
            end else begin
              ctx_out.lengths[axis] = hsu_pkg::LEN_BITS'(signed'(travel_in));
              if (axis) begin
                ctx_out.phase = hsu_pkg::PH_DONE;
                ctx_out.busy  = 1'b0;
              end else begin
                ctx_out.phase = hsu_pkg::PH_Y_FIRST;
              end
            end
          end
          default: begin
            ctx_out.busy = 1'b0;
          end
        endcase
      end
    end

    // A step ends the tick for the stepping axis
    if (do_step) begin
      ctx_out.busy = 1'b0;
      if (axis) begin
        ctx_out.step_y = 1'b1;
        ctx_out.dir_y  = step_level;
      end else begin
        ctx_out.step_x = 1'b1;
        ctx_out.dir_x  = step_level;
      end
    end
  end

endmodule

FILE: sv/hsu_step_chain.sv
// Cascade of phase-rule evaluations that resolves all fall-through phases of one tick.
// Depends on hsu_pkg and hsu_rule.
module hsu_step_chain #(
  parameter int COUNT_BITS = 24
) (
  input  hsu_pkg::hsu_cfg_t                 cfg,
  input  logic [hsu_pkg::SWITCH_BITS-1:0]   closed,
  input  hsu_pkg::hsu_ctx_t                 ctx_in,
  input  logic [COUNT_BITS-1:0]             travel_in,
  output hsu_pkg::hsu_ctx_t                 ctx_out,
  output logic [COUNT_BITS-1:0]             travel_out
);

  hsu_pkg::hsu_ctx_t       ctx_link    [hsu_pkg::RULE_PASSES+1];
  logic [COUNT_BITS-1:0]   travel_link [hsu_pkg::RULE_PASSES+1];

  assign ctx_link[0]    = ctx_in;
  assign travel_link[0] = travel_in;

  // Chain the rule; later passes see the phase left by earlier ones
  for (genvar g = 0; g < hsu_pkg::RULE_PASSES; g++) begin : g_pass
    hsu_rule #(
      .COUNT_BITS (COUNT_BITS)
    ) u_rule (
      .cfg        (cfg),
      .closed     (closed),
      .ctx_in     (ctx_link[g]),
      .travel_in  (travel_link[g]),
      .ctx_out    (ctx_link[g+1]),
      .travel_out (travel_link[g+1])
    );
  end

  assign ctx_out    = ctx_link[hsu_pkg::RULE_PASSES];
  assign travel_out = travel_link[hsu_pkg::RULE_PASSES];

endmodule

FILE: sv/two_axis_homing_sequencer_unit.sv
// Two-axis homing sequencer: one tick in, one step/status word out, one per cycle while
// the output side is ready. Ticks are registered on entry, resolved by the phase-rule
// chain, and the result is registered on exit, so a tick is accepted every cycle on that
// condition. The four-pass phase-rule chain between the input register and the result
// register sets the critical path. The result register parts the two sides: a new tick is
// taken while a finished result still waits. No clearing pass is needed after reset.
// Configuration is applied to the ticks processed after the write.
// Depends on hsu_pkg, hsu_step_chain and assert_macros.svh.
`include "assert_macros.svh"

module two_axis_homing_sequencer_unit #(
  parameter int COUNT_BITS = 24
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // Configuration writes
  input  logic                                  cfg_wr_en,
  input  logic [hsu_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [hsu_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  // Tick stream in
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // tdata from bit 0: start_req[0], switch_levels[4:1], zero fill[7:5]
  input  logic [hsu_pkg::IN_TDATA_BITS-1:0]     s_axis_tdata,
  // Result stream out
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // tdata from bit 0: step_x[0], dir_x[1], step_y[2], dir_y[3], phase[7:4], done_res[8],
  // x_length[32:9], y_length[56:33], x_pos_switch[58:57], x_neg_switch[60:59],
  // y_pos_switch[62:61], y_neg_switch[64:63], zero fill[71:65]
  output logic [hsu_pkg::OUT_TDATA_BITS-1:0]    m_axis_tdata
);

  // Configuration registers
  hsu_pkg::hsu_cfg_t                         cfg;

  // Input register
  logic                                      in_valid;
  logic                                      in_start;
  logic [hsu_pkg::SWITCH_BITS-1:0]           in_closed;

  // Sequencer state
  logic [hsu_pkg::PHASE_BITS-1:0]            phase;
  logic [COUNT_BITS-1:0]                     travel_count;
  logic [hsu_pkg::MARGIN_BITS-1:0]           margin_left;
  logic [3:0][hsu_pkg::SW_IDX_BITS-1:0]      found;
  logic [1:0][hsu_pkg::LEN_BITS-1:0]         lengths;

  // Rule chain
  hsu_pkg::hsu_ctx_t                         ctx_start;
  hsu_pkg::hsu_ctx_t                         ctx_end;
  logic [COUNT_BITS-1:0]                     travel_end;

  logic                                      in_xfer;
  logic                                      advance;

  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // Configuration writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_dir        <= 1'b0;
      cfg.y_dir        <= 1'b0;
      cfg.margin_steps <= 16'd100;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        hsu_pkg::CFG_X_DIR:  cfg.x_dir        <= cfg_data[0];
        hsu_pkg::CFG_Y_DIR:  cfg.y_dir        <= cfg_data[0];
        hsu_pkg::CFG_MARGIN: cfg.margin_steps <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register: hold the tick until it moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_xfer) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_start  <= s_axis_tdata[0];
      in_closed <= s_axis_tdata[4:1] & hsu_pkg::SWITCH_MASK;
    end
  end

  // Build the starting context of the tick
  always_comb begin
    ctx_start             = '0;
    ctx_start.busy        = 1'b1;
    ctx_start.start       = in_start;
    ctx_start.phase       = phase;
    ctx_start.margin_left = margin_left;
    ctx_start.found       = found;
    ctx_start.lengths     = lengths;
  end

  hsu_step_chain #(
    .COUNT_BITS (COUNT_BITS)
  ) u_chain (
    .cfg        (cfg),
    .closed     (in_closed),
    .ctx_in     (ctx_start),
    .travel_in  (travel_count),
    .ctx_out    (ctx_end),
    .travel_out (travel_end)
  );

  // Commit state when the tick advances
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= hsu_pkg::PH_IDLE;
      travel_count <= '0;
      margin_left  <= '0;
      found        <= '0;
      lengths      <= '0;
    end else if (advance) begin
      phase        <= ctx_end.phase;
      travel_count <= travel_end;
      margin_left  <= ctx_end.margin_left;
      found        <= ctx_end.found;
      lengths      <= ctx_end.lengths;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tdata <= {7'd0,
                       ctx_end.found[3], ctx_end.found[2],
                       ctx_end.found[1], ctx_end.found[0],
                       ctx_end.lengths[1], ctx_end.lengths[0],
                       (ctx_end.phase == hsu_pkg::PH_DONE),
                       ctx_end.phase,
                       ctx_end.dir_y, ctx_end.step_y,
                       ctx_end.dir_x, ctx_end.step_x};
    end
  end

  // The rule chain must settle within its passes
  `HSU_ASSERT(a_chain_settles, advance |-> !ctx_end.busy, "rule chain still busy at commit")
  // Only one axis moves per tick
  `HSU_ASSERT(a_one_axis, advance |-> !(ctx_end.step_x && ctx_end.step_y), "both axes stepped")
  // The unused phase code is never entered; the phase is unknown until reset lands
  `HSU_ASSERT_ALWAYS(a_no_unused_phase, rst || (phase != hsu_pkg::PH_UNUSED), "unused phase entered")
  // A held tick keeps its switch levels until it advances
  `HSU_ASSERT(a_input_hold, (in_valid && !advance) |=> (in_valid && $stable(in_closed)),
              "held tick changed")

endmodule
